// File: rtl/core/gdd_pkg.sv
// shared constants, types and microcode table for the downhill drop grid
package gdd_pkg;

  // grid geometry
  localparam int unsigned GRID_SIDE  = 64;
  localparam int unsigned COORD_W    = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
  localparam int unsigned CELL_COUNT = GRID_SIDE * GRID_SIDE;
  localparam int unsigned CELL_W     = $clog2(CELL_COUNT);

  // fixed field widths of the channels
  localparam int unsigned OP_W    = 2;
  localparam int unsigned FIELD_W = 6;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned ENTRY_W = LEVEL_W + 1;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [CELL_W-1:0]  cell_t;
  typedef logic [LEVEL_W-1:0] level_t;

  typedef enum logic [OP_W-1:0] {
    OP_DROP = 2'd0,
    OP_LOAD = 2'd1,
    OP_READ = 2'd2
  } op_e;

  // microcode steps
  typedef enum logic [3:0] {
    S_IDLE    = 4'd0,
    S_D_CUR   = 4'd1,
    S_D_HERE  = 4'd2,
    S_D_LEFT  = 4'd3,
    S_D_RIGHT = 4'd4,
    S_D_UP    = 4'd5,
    S_D_DOWN  = 4'd6,
    S_D_WET   = 4'd7,
    S_EMIT    = 4'd8,
    S_L_WR    = 4'd9,
    S_R_CUR   = 4'd10,
    S_R_DATA  = 4'd11
  } step_e;

  typedef enum logic [2:0] {
    NBR_CUR   = 3'd0,
    NBR_LEFT  = 3'd1,
    NBR_RIGHT = 3'd2,
    NBR_UP    = 3'd3,
    NBR_DOWN  = 3'd4
  } nbr_e;

  typedef enum logic [1:0] {
    WR_NONE = 2'd0,
    WR_LOAD = 2'd1,
    WR_DROP = 2'd2
  } wr_e;

  typedef enum logic [2:0] {
    COND_NEXT     = 3'd0,
    COND_JUMP     = 3'd1,
    COND_DISPATCH = 3'd2,
    COND_LOWER    = 3'd3,
    COND_EMIT     = 3'd4
  } cond_e;

  // one control word
  typedef struct packed {
    nbr_e  addr;     // cell whose entry is read
    logic  rd;       // issue a read
    logic  here_ld;  // capture read data as the current cell
    nbr_e  cmp;      // neighbor checked against the current cell
    wr_e   wr;       // write back the current cell
    cond_e cond;     // how the step counter moves
    step_e target;   // jump destination
  } ctrl_t;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic            go;        // word accepted this cycle
    logic [OP_W-1:0] op;        // its op code
    logic            lower;     // checked neighbor is valid and strictly lower
    logic            out_free;  // result register can take a new word
  } seq_stat_t;

  function automatic ctrl_t ucode(input step_e s);
    ctrl_t w;
    w = '{addr: NBR_CUR, rd: 1'b0, here_ld: 1'b0, cmp: NBR_CUR, wr: WR_NONE,
          cond: COND_NEXT, target: S_IDLE};
    case (s)
      S_IDLE:    w.cond = COND_DISPATCH;
      S_D_CUR:   w.rd = 1'b1;
      S_D_HERE: begin
        w.here_ld = 1'b1;
        w.addr    = NBR_LEFT;
        w.rd      = 1'b1;
      end
      S_D_LEFT: begin
        w.cmp = NBR_LEFT;  w.addr = NBR_RIGHT; w.rd = 1'b1;
        w.cond = COND_LOWER; w.target = S_D_CUR;
      end
      S_D_RIGHT: begin
        w.cmp = NBR_RIGHT; w.addr = NBR_UP;    w.rd = 1'b1;
        w.cond = COND_LOWER; w.target = S_D_CUR;
      end
      S_D_UP: begin
        w.cmp = NBR_UP;    w.addr = NBR_DOWN;  w.rd = 1'b1;
        w.cond = COND_LOWER; w.target = S_D_CUR;
      end
      S_D_DOWN: begin
        w.cmp = NBR_DOWN;
        w.cond = COND_LOWER; w.target = S_D_CUR;
      end
      S_D_WET:   w.wr = WR_DROP;
      S_EMIT: begin
        w.cond   = COND_EMIT;
        w.target = S_IDLE;
      end
      S_L_WR: begin
        w.wr     = WR_LOAD;
        w.cond   = COND_JUMP;
        w.target = S_EMIT;
      end
      S_R_CUR:   w.rd = 1'b1;
      S_R_DATA: begin
        w.here_ld = 1'b1;
        w.cond    = COND_JUMP;
        w.target  = S_EMIT;
      end
      default: begin
        w.cond   = COND_JUMP;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

  // out-of-grid coordinates saturate to the last row or column
  function automatic coord_t clamp_coord(input logic [FIELD_W-1:0] v);
    if (int'(v) >= int'(GRID_SIDE)) begin
      return coord_t'(GRID_SIDE - 1);
    end
    return coord_t'(v);
  endfunction

  function automatic cell_t cell_addr(input coord_t x, input coord_t y);
    return CELL_W'(int'(y) * int'(GRID_SIDE) + int'(x));
  endfunction

endpackage

// File: rtl/core/gdd_if.sv
// valid/ready channels for input words and result words
interface gdd_in_if;
  logic                        valid;
  logic                        ready;
  logic [gdd_pkg::OP_W-1:0]    op;
  logic [gdd_pkg::FIELD_W-1:0] cell_x;
  logic [gdd_pkg::FIELD_W-1:0] cell_y;
  logic [gdd_pkg::LEVEL_W-1:0] load_level;

  modport source (output valid, op, cell_x, cell_y, load_level, input ready);
  modport sink   (input valid, op, cell_x, cell_y, load_level, output ready);
endinterface

interface gdd_out_if;
  logic                        valid;
  logic                        ready;
  logic [gdd_pkg::FIELD_W-1:0] rest_x;
  logic [gdd_pkg::FIELD_W-1:0] rest_y;
  logic [gdd_pkg::LEVEL_W-1:0] cell_level;
  logic                        cell_wet;

  modport source (output valid, rest_x, rest_y, cell_level, cell_wet, input ready);
  modport sink   (input valid, rest_x, rest_y, cell_level, cell_wet, output ready);
endinterface

// File: rtl/core/grid_drop_descend_deposit_top.sv
// downhill drop grid: cell memory, walk datapath and microcoded control
//
//  channel | dir | fields                                  | taken when
//  --------+-----+-----------------------------------------+---------------------------
//  in_i    | in  | op, cell_x, cell_y, load_level          | in_i.valid & in_i.ready
//  out_o   | out | rest_x, rest_y, cell_level, cell_wet    | out_o.valid & out_o.ready
//
//  one word at a time; the result lands in an output register, so the next word
//  can be taken while it waits. a load writes its cell, a read fetches it, and a
//  drop rereads its cell and neighbors after each downhill move (one read per neighbor, left first)
//  through the single read port of the cell memory; at most 255 moves.
//  after reset a clearing pass writes zero to all 4096 cells, one per cycle,
//  with in_i.ready low until the pass ends.
//  a busy output stalls the sequencer in its result step only.
module grid_drop_descend_deposit_top (
  input  logic     clk_i,
  input  logic     rst_ni,
  gdd_in_if.sink   in_i,
  gdd_out_if.source out_o
);

  // sequencer
  gdd_pkg::ctrl_t     ctrl;
  gdd_pkg::step_e     step;
  gdd_pkg::seq_stat_t stat;

  // datapath state
  gdd_pkg::coord_t x_q;
  gdd_pkg::coord_t y_q;
  gdd_pkg::level_t here_q;
  logic            wet_q;
  gdd_pkg::level_t load_q;

  // cell memory: {wet, level} per cell, no reset, cleared by the sweep
  logic [gdd_pkg::ENTRY_W-1:0] mem_q [gdd_pkg::CELL_COUNT];
  logic [gdd_pkg::ENTRY_W-1:0] rd_q;
  logic                        mem_we;
  gdd_pkg::cell_t              mem_waddr;
  logic [gdd_pkg::ENTRY_W-1:0] mem_wdata;
  gdd_pkg::cell_t              mem_raddr;

  // clearing sweep
  logic           clr_q;
  gdd_pkg::cell_t clr_idx_q;

  // output register
  logic                        out_valid_q;
  logic [gdd_pkg::FIELD_W-1:0] out_x_q;
  logic [gdd_pkg::FIELD_W-1:0] out_y_q;
  gdd_pkg::level_t             out_level_q;
  logic                        out_wet_q;

  logic            in_fire;
  logic            out_free;
  logic            emit;
  gdd_pkg::coord_t rx;
  gdd_pkg::coord_t ry;
  logic            cmp_ok;
  logic            lower;
  gdd_pkg::level_t drop_level;

  gdd_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .step_o (step)
  );

  // handshakes
  assign in_i.ready = (ctrl.cond == gdd_pkg::COND_DISPATCH) && !clr_q;
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign emit       = (ctrl.cond == gdd_pkg::COND_EMIT) && out_free;

  // neighbor read address; an edge neighbor falls back to the current cell
  always_comb begin
    rx = x_q;
    ry = y_q;
    case (ctrl.addr)
      gdd_pkg::NBR_LEFT:  if (x_q != '0) rx = x_q - gdd_pkg::coord_t'(1);
      gdd_pkg::NBR_RIGHT:
        if (x_q != gdd_pkg::coord_t'(gdd_pkg::GRID_SIDE - 1)) rx = x_q + gdd_pkg::coord_t'(1);
      gdd_pkg::NBR_UP:    if (y_q != '0) ry = y_q - gdd_pkg::coord_t'(1);
      gdd_pkg::NBR_DOWN:
        if (y_q != gdd_pkg::coord_t'(gdd_pkg::GRID_SIDE - 1)) ry = y_q + gdd_pkg::coord_t'(1);
      default: ;
    endcase
  end

  assign mem_raddr = gdd_pkg::cell_addr(rx, ry);

  // is the neighbor read last step inside the grid
  always_comb begin
    case (ctrl.cmp)
      gdd_pkg::NBR_LEFT:  cmp_ok = (x_q != '0);
      gdd_pkg::NBR_RIGHT: cmp_ok = (x_q != gdd_pkg::coord_t'(gdd_pkg::GRID_SIDE - 1));
      gdd_pkg::NBR_UP:    cmp_ok = (y_q != '0);
      gdd_pkg::NBR_DOWN:  cmp_ok = (y_q != gdd_pkg::coord_t'(gdd_pkg::GRID_SIDE - 1));
      default:            cmp_ok = 1'b0;
    endcase
  end

  assign lower = cmp_ok && (rd_q[gdd_pkg::LEVEL_W-1:0] < here_q);

  assign stat = '{go: in_fire, op: in_i.op, lower: lower, out_free: out_free};

  // saturating deposit
  assign drop_level = (here_q == '1) ? here_q : here_q + gdd_pkg::level_t'(1);

  // write port: sweep first, then the step's write-back
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = gdd_pkg::cell_addr(x_q, y_q);
    mem_wdata = '0;
    if (clr_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_q;
    end else begin
      case (ctrl.wr)
        gdd_pkg::WR_LOAD: begin
          mem_we    = 1'b1;
          mem_wdata = {1'b0, load_q};
        end
        gdd_pkg::WR_DROP: begin
          mem_we    = 1'b1;
          mem_wdata = {1'b1, drop_level};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (ctrl.rd) begin
      rd_q <= mem_q[mem_raddr];
    end
  end

  // clearing sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
    end else if (clr_q) begin
      if (clr_idx_q == gdd_pkg::cell_t'(gdd_pkg::CELL_COUNT - 1)) begin
        clr_q <= 1'b0;
      end
      clr_idx_q <= clr_idx_q + gdd_pkg::cell_t'(1);
    end
  end

  // walk position, current cell and result level/flag
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q    <= gdd_pkg::clamp_coord(in_i.cell_x);
      y_q    <= gdd_pkg::clamp_coord(in_i.cell_y);
      load_q <= in_i.load_level;
    end
    if (ctrl.here_ld) begin
      here_q <= rd_q[gdd_pkg::LEVEL_W-1:0];
      wet_q  <= rd_q[gdd_pkg::LEVEL_W];
    end
    if (ctrl.cond == gdd_pkg::COND_LOWER && lower) begin
      case (ctrl.cmp)
        gdd_pkg::NBR_LEFT:  x_q <= x_q - gdd_pkg::coord_t'(1);
        gdd_pkg::NBR_RIGHT: x_q <= x_q + gdd_pkg::coord_t'(1);
        gdd_pkg::NBR_UP:    y_q <= y_q - gdd_pkg::coord_t'(1);
        gdd_pkg::NBR_DOWN:  y_q <= y_q + gdd_pkg::coord_t'(1);
        default: ;
      endcase
    end
    if (!clr_q) begin
      case (ctrl.wr)
        gdd_pkg::WR_LOAD: begin
          here_q <= load_q;
          wet_q  <= 1'b0;
        end
        gdd_pkg::WR_DROP: begin
          here_q <= drop_level;
          wet_q  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_x_q     <= gdd_pkg::FIELD_W'(x_q);  // wide grids report low bits
      out_y_q     <= gdd_pkg::FIELD_W'(y_q);
      out_level_q <= here_q;
      out_wet_q   <= wet_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.rest_x     = out_x_q;
  assign out_o.rest_y     = out_y_q;
  assign out_o.cell_level = out_level_q;
  assign out_o.cell_wet   = out_wet_q;

`ifndef ASSERT_OFF
  // no word taken while the sweep runs
  a_no_take_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !in_i.ready)
    else $error("word taken during clearing sweep");

  // sweep ends only after the last cell
  a_clr_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clr_q) |-> $past(clr_idx_q) == gdd_pkg::cell_t'(gdd_pkg::CELL_COUNT - 1))
    else $error("clearing sweep ended early");

  // the walk never leaves the grid
  a_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step != gdd_pkg::S_IDLE) |->
      (int'(x_q) < int'(gdd_pkg::GRID_SIDE)) && (int'(y_q) < int'(gdd_pkg::GRID_SIDE)))
    else $error("walk left the grid");

  // an accepted word makes the block busy next cycle
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_i.ready)
    else $error("ready stayed high after a word was taken");
`endif

endmodule

// File: rtl/core/gdd_useq.sv
// microcode step counter with op dispatch and conditional jumps
module gdd_useq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gdd_pkg::seq_stat_t  stat_i,
  output gdd_pkg::ctrl_t      ctrl_o,
  output gdd_pkg::step_e      step_o
);

  gdd_pkg::step_e pc_q, pc_d;
  gdd_pkg::ctrl_t ctrl;
  gdd_pkg::step_e pc_inc;

  assign ctrl   = gdd_pkg::ucode(pc_q);
  assign pc_inc = gdd_pkg::step_e'(pc_q + 4'd1);

  always_comb begin
    pc_d = pc_q;
    case (ctrl.cond)
      gdd_pkg::COND_NEXT: pc_d = pc_inc;
      gdd_pkg::COND_JUMP: pc_d = ctrl.target;
      gdd_pkg::COND_DISPATCH: begin
        if (stat_i.go) begin
          case (stat_i.op)
            gdd_pkg::OP_DROP: pc_d = gdd_pkg::S_D_CUR;
            gdd_pkg::OP_LOAD: pc_d = gdd_pkg::S_L_WR;
            default:          pc_d = gdd_pkg::S_R_CUR;  // unused code reads
          endcase
        end
      end
      gdd_pkg::COND_LOWER: pc_d = stat_i.lower ? ctrl.target : pc_inc;
      gdd_pkg::COND_EMIT:  pc_d = stat_i.out_free ? ctrl.target : pc_q;
      default:             pc_d = gdd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= gdd_pkg::S_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = ctrl;
  assign step_o = pc_q;

`ifndef ASSERT_OFF
  // a word is only taken in the idle step
  a_go_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.go |-> pc_q == gdd_pkg::S_IDLE)
    else $error("word taken outside idle step");

  // a stalled result step holds
  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == gdd_pkg::S_EMIT && !stat_i.out_free) |=> pc_q == gdd_pkg::S_EMIT)
    else $error("result step left while output busy");

  // a downhill move restarts the walk at the new cell
  a_move_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.cond == gdd_pkg::COND_LOWER && stat_i.lower) |=> pc_q == gdd_pkg::S_D_CUR)
    else $error("downhill move did not restart walk");
`endif

endmodule
